@@ rtl/sha256_hash_macros.svh @@
// Assertion macros for the checker file of the hasher.
// Depends on nothing; included by sha256_hash_checker.sv.
`ifndef SHA256_HASH_MACROS_SVH
`define SHA256_HASH_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/sha_pkg.sv @@
// Shared types, constants and functions of the SHA-256 hasher.
// Depends on nothing; used by every module of the hasher.
package sha_pkg;

	// One input word: a byte with its flags.
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       no_data;
		logic       end_of_message;
	} in_word_t;

	// One result word: a digest word with its position.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	// Entry of the queue between front and back.
	typedef struct packed {
		logic [7:0] data;
		logic       is_len;
	} byte_cmd_t;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = 2;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_PAD80,
		FR_ZERO,
		FR_LEN,
		FR_WAIT
	} front_state_t;

	typedef enum logic [1:0] {
		BK_FILL,
		BK_ROUND,
		BK_ADD,
		BK_OUT
	} back_state_t;

	localparam logic [7:0] PadByte = 8'b1000_0000;
	localparam logic [5:0] LenPos  = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ rtl/sha_front.sv @@
// Front part: takes message words, counts bits and emits the padded byte stream.
// Depends on sha_pkg.
module sha_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sha_pkg::in_word_t   in_word,
	output logic                q_push,
	input  logic                q_full,
	output sha_pkg::byte_cmd_t  q_data,
	input  logic                done
);

	sha_pkg::front_state_t state_q, state_d;
	logic [63:0] bit_count_q;
	logic [5:0]  pos_q;
	logic [2:0]  len_idx_q;
	logic        acc;
	logic        emit;

	// State register and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha_pkg::FR_IDLE;
			bit_count_q <= '0;
			pos_q       <= '0;
			len_idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc && !in_word.no_data)
				bit_count_q <= bit_count_q + 64'd8;
			if (emit)
				pos_q <= pos_q + 6'd1;
			if (state_q == sha_pkg::FR_LEN && emit)
				len_idx_q <= len_idx_q + 3'd1;
			if (state_q == sha_pkg::FR_WAIT && done) begin
				bit_count_q <= '0;
				len_idx_q   <= '0;
			end
		end
	end

	// Next state and byte output.
	always_comb begin
		state_d = state_q;
		acc     = 1'b0;
		emit    = 1'b0;
		full    = 1'b1;
		q_push  = 1'b0;
		q_data  = '0;
		unique case (state_q)
			sha_pkg::FR_IDLE: begin
				full = q_full;
				acc  = push && !q_full;
				if (acc) begin
					q_push = !in_word.no_data;
					emit   = q_push;
					q_data.data = in_word.msg_byte;
					if (in_word.end_of_message)
						state_d = sha_pkg::FR_PAD80;
				end
			end
			sha_pkg::FR_PAD80: begin
				q_push = !q_full;
				emit   = q_push;
				q_data.data = sha_pkg::PadByte;
				if (emit)
					state_d = (pos_q + 6'd1 == sha_pkg::LenPos) ?
						sha_pkg::FR_LEN : sha_pkg::FR_ZERO;
			end
			sha_pkg::FR_ZERO: begin
				q_push = !q_full;
				emit   = q_push;
				if (emit && pos_q + 6'd1 == sha_pkg::LenPos)
					state_d = sha_pkg::FR_LEN;
			end
			sha_pkg::FR_LEN: begin
				q_push = !q_full;
				emit   = q_push;
				q_data.data = bit_count_q[63 - 8*len_idx_q -: 8];
				q_data.is_len = (len_idx_q == 3'd7);
				if (emit && len_idx_q == 3'd7)
					state_d = sha_pkg::FR_WAIT;
			end
			sha_pkg::FR_WAIT: begin
				if (done)
					state_d = sha_pkg::FR_IDLE;
			end
			default: state_d = sha_pkg::FR_IDLE;
		endcase
	end

endmodule

@@ rtl/sha_queue.sv @@
// Short queue of padded bytes between front and back.
// Depends on sha_pkg.
module sha_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  sha_pkg::byte_cmd_t wdata,
	output logic               qfull,
	input  logic               rd,
	output logic               qempty,
	output sha_pkg::byte_cmd_t rdata
);

	sha_pkg::byte_cmd_t mem_q [sha_pkg::QDepth];
	logic [sha_pkg::QAw:0] wp_q, rp_q;

	assign qempty = (wp_q == rp_q);
	assign qfull  = (wp_q[sha_pkg::QAw] != rp_q[sha_pkg::QAw]) &&
		(wp_q[sha_pkg::QAw-1:0] == rp_q[sha_pkg::QAw-1:0]);
	assign rdata  = mem_q[rp_q[sha_pkg::QAw-1:0]];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr && !qfull)
			mem_q[wp_q[sha_pkg::QAw-1:0]] <= wdata;
	end

	// Pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr && !qfull)
				wp_q <= wp_q + 1'b1;
			if (rd && !qempty)
				rp_q <= rp_q + 1'b1;
		end
	end

endmodule

@@ rtl/sha_back.sv @@
// Back part: packs bytes into a block, runs 64 rounds and hands out the digest.
// Depends on sha_pkg.
module sha_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               qempty,
	input  sha_pkg::byte_cmd_t qdata,
	output logic               qpop,
	output logic               empty,
	input  logic               pop,
	output sha_pkg::out_word_t out_word,
	output logic               done
);

	sha_pkg::back_state_t state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        final_q;
	logic [31:0] wt, s0w, s1w, s0, s1, ch, mj, t1, t2;
	logic [3:0]  r4;

	assign r4 = rnd_q[3:0];

	// Message word and round terms of the current round, from the sliding schedule window.
	always_comb begin
		s0w = sha_pkg::rotr(w_q[r4 + 4'd1], 7) ^ sha_pkg::rotr(w_q[r4 + 4'd1], 18) ^
			(w_q[r4 + 4'd1] >> 3);
		s1w = sha_pkg::rotr(w_q[r4 + 4'd14], 17) ^ sha_pkg::rotr(w_q[r4 + 4'd14], 19) ^
			(w_q[r4 + 4'd14] >> 10);
		wt  = (rnd_q < 6'd16) ? w_q[r4] : w_q[r4] + s0w + w_q[r4 + 4'd9] + s1w;
		s1  = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + s1 + ch + sha_pkg::ROUND_K[rnd_q] + wt;
		s0  = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
		mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2  = s0 + mj;
	end

	// Next state and control outputs.
	always_comb begin
		state_d = state_q;
		qpop    = 1'b0;
		empty   = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			sha_pkg::BK_FILL: begin
				qpop = !qempty;
				if (qpop && pos_q == 6'd63)
					state_d = sha_pkg::BK_ROUND;
			end
			sha_pkg::BK_ROUND: begin
				if (rnd_q == 6'd63)
					state_d = sha_pkg::BK_ADD;
			end
			sha_pkg::BK_ADD: state_d = final_q ? sha_pkg::BK_OUT : sha_pkg::BK_FILL;
			sha_pkg::BK_OUT: begin
				empty = 1'b0;
				if (pop && oidx_q == 3'd7) begin
					state_d = sha_pkg::BK_FILL;
					done    = 1'b1;
				end
			end
			default: state_d = sha_pkg::BK_FILL;
		endcase
	end

	assign out_word.digest_word = h_q[oidx_q];
	assign out_word.word_index  = oidx_q;
	assign out_word.last_word   = (oidx_q == 3'd7);

	// Block window: bytes are written by position during fill, rounds overwrite in place.
	always_ff @(posedge clk) begin
		if (state_q == sha_pkg::BK_FILL && qpop)
			w_q[pos_q[5:2]][31 - 8*pos_q[1:0] -: 8] <= qdata.data;
		if (state_q == sha_pkg::BK_ROUND)
			w_q[r4] <= wt;
	end

	// Chaining, working variables and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::BK_FILL;
			pos_q   <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			final_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::INIT_H[i];
				v_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sha_pkg::BK_FILL: begin
					if (qpop) begin
						pos_q <= pos_q + 6'd1;
						if (pos_q == 6'd63) begin
							final_q <= qdata.is_len;
							for (int i = 0; i < 8; i++)
								v_q[i] <= h_q[i];
						end
					end
				end
				sha_pkg::BK_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
				end
				sha_pkg::BK_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
				end
				sha_pkg::BK_OUT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							final_q <= 1'b0;
							for (int i = 0; i < 8; i++)
								h_q[i] <= sha_pkg::INIT_H[i];
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/sha256_hash.sv @@
// Channel | handshake   | payload
// input   | push / full | in_word  (msg_byte, no_data, end_of_message)
// result  | pop / empty | out_word (digest_word, word_index, last_word)
// The front passes each data byte to the byte queue; each 64-byte block is
// filled, run through its rounds and added in the back, which pops no bytes
// until the add is done, as there is a single round unit. Padding adds up to
// 72 bytes. Eight result words follow the last block. Reset is asynchronous
// and loads the initial hash values; full rises while the byte queue is full
// or the message tail is being padded, hashed and read out.
module sha256_hash (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sha_pkg::in_word_t  in_word,
	output logic               empty,
	input  logic               pop,
	output sha_pkg::out_word_t out_word
);

	logic               q_push, q_full, q_pop, q_empty, done;
	sha_pkg::byte_cmd_t q_wdata, q_rdata;

	sha_front u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.q_push, .q_full, .q_data(q_wdata), .done
	);

	sha_queue u_queue (
		.clk, .arst_n, .wr(q_push), .wdata(q_wdata), .qfull(q_full),
		.rd(q_pop), .qempty(q_empty), .rdata(q_rdata)
	);

	sha_back u_back (
		.clk, .arst_n, .qempty(q_empty), .qdata(q_rdata), .qpop(q_pop),
		.empty, .pop, .out_word, .done
	);

endmodule

@@ rtl/sha256_hash_checker.sv @@
// Port-level checker of the hasher, bound to the top level.
// Depends on sha_pkg and sha256_hash_macros.svh.
`include "sha256_hash_macros.svh"
module sha256_hash_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input sha_pkg::out_word_t out_word
);

	// A waiting result word holds until popped.
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_word))
	// Last marker sits on the eighth word only.
	`SHA_ASSERT_IMP(a_last, clk, arst_n, !empty, out_word.last_word == (out_word.word_index == 3'd7))
	// Popping a word advances the index unless it was the last.
	`SHA_ASSERT_NEXT(a_next, clk, arst_n, !empty && pop && !out_word.last_word, !empty && out_word.word_index == $past(out_word.word_index) + 3'd1)
	// Input is held off while results are shown.
	`SHA_ASSERT_IMP(a_stall, clk, arst_n, !empty, full)

endmodule

bind sha256_hash sha256_hash_checker u_checker (
	.clk, .arst_n, .full, .empty, .pop, .out_word
);
